[src/cpsrw_pkg.sv]
// cpsrw_pkg: shared types, constants and state codes for the sweep register word generator.
// No dependencies; used by every module under src but cpsrw_fifo and cpsrw_checker.
package cpsrw_pkg;

  // queue depths
  localparam int unsigned IN_DEPTH_DEF  = 2;
  localparam int unsigned OUT_DEPTH_DEF = 2;

  // arithmetic limits
  localparam logic [11:0] WORD12_MAX = 12'd4095;
  localparam logic [19:0] STEPS_MAX  = 20'd1048575;
  localparam logic [15:0] DEV_MAX    = 16'd65535;
  localparam logic [3:0]  OFFS_MAX   = 4'd15;

  // divider geometry
  localparam int unsigned DIV_NW = 41;
  localparam int unsigned DIV_DW = 40;
  localparam logic [5:0]  ITER_DWORD = 6'd21;
  localparam logic [5:0]  ITER_STEPS = 6'd22;
  localparam logic [5:0]  ITER_DEV   = 6'd41;

  // fixed bits of the register words
  localparam logic [31:0] R7_FIXED = 32'h0007_8007;
  localparam logic [31:0] R6_FIXED = 32'h0000_0006;
  localparam logic [31:0] R5_FIXED = 32'h0000_0005;
  localparam logic [31:0] R4_WORD  = 32'h0078_0084;
  localparam logic [31:0] R3_FIXED = 32'h0000_0043;
  localparam logic [31:0] R2_FIXED = 32'h1E41_0002;
  localparam logic [31:0] R1_WORD  = 32'h0000_0001;
  localparam logic [31:0] R0_FIXED = 32'hF800_0000;

  // word index in emit order
  localparam logic [2:0] IDX_R7 = 3'd0;
  localparam logic [2:0] IDX_R6 = 3'd1;
  localparam logic [2:0] IDX_R5 = 3'd2;
  localparam logic [2:0] IDX_R4 = 3'd3;
  localparam logic [2:0] IDX_R3 = 3'd4;
  localparam logic [2:0] IDX_R2 = 3'd5;
  localparam logic [2:0] IDX_R1 = 3'd6;
  localparam logic [2:0] IDX_R0 = 3'd7;

  // classified request from the front part
  typedef struct packed {
    logic [20:0] count;     // max(1, 20*delay)
    logic [8:0]  clk1;      // ceil(count/4095)
    logic [21:0] rt40;      // 40*ramp time
    logic [15:0] bw;
    logic [11:0] integ;
    logic        fmsb;
    logic        ramp_tri;
  } item_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } oword_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;  // left aligned
    logic [DIV_DW-1:0] den;
    logic [5:0]        iters;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_CLK1,
    BS_DWORD,
    BS_STEPS,
    BS_OFFS,
    BS_DEV,
    BS_EMIT
  } back_state_t;

endpackage

[src/cpsrw_fifo.sv]
// cpsrw_fifo: small register queue with push/full and pop/empty sides.
// Depends on nothing; used for the request queue and the word queue.
module cpsrw_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule

[src/cpsrw_front.sv]
// cpsrw_front: takes sweep requests, derives the fixed-ratio terms and queues them.
// Depends on cpsrw_pkg and cpsrw_fifo.
module cpsrw_front #(
  parameter int unsigned DEPTH = cpsrw_pkg::IN_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic [15:0]         ramp_time_us,
  input  logic [15:0]         ramp_delay_us,
  input  logic [15:0]         start_freq_10mhz,
  input  logic [15:0]         bandwidth_mhz,
  input  logic                triangular,
  output cpsrw_pkg::item_t    item,
  output logic                item_valid,
  input  logic                item_pop
);
  cpsrw_pkg::item_t cls;
  logic [20:0]      cnt20;
  logic [20:0]      clk1_num;
  logic [12:0]      c_sum;
  logic             q_empty;
  logic [$bits(cpsrw_pkg::item_t)-1:0] q_rdata;

  // classify: delay in PFD periods, ramp time scaled by 40, clock divider rounded up, frequency split
  always_comb begin
    cnt20        = 21'(ramp_delay_us) * 21'd20;
    cls.count    = (cnt20 == '0) ? 21'd1 : cnt20;
    clk1_num     = cls.count + 21'(cpsrw_pkg::WORD12_MAX) - 21'd1;
    // n/4095 with n = 4096*hi + lo = 4095*hi + (hi + lo), and hi + lo < 2*4095
    c_sum        = 13'(clk1_num[20:12]) + 13'(clk1_num[11:0]);
    cls.clk1     = clk1_num[20:12] + 9'(c_sum >= 13'(cpsrw_pkg::WORD12_MAX));
    cls.rt40     = 22'(ramp_time_us) * 22'd40;
    cls.bw       = bandwidth_mhz;
    cls.integ    = start_freq_10mhz[12:1];
    cls.fmsb     = start_freq_10mhz[0];
    cls.ramp_tri = triangular;
  end

  cpsrw_fifo #(.W($bits(cpsrw_pkg::item_t)), .DEPTH(DEPTH)) u_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (item_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign item       = cpsrw_pkg::item_t'(q_rdata);
  assign item_valid = !q_empty;
endmodule

[src/cpsrw_div.sv]
// cpsrw_div: restoring divider, one quotient bit a cycle, left-aligned numerator.
// Depends on cpsrw_pkg (request/response types).
module cpsrw_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cpsrw_pkg::div_req_t   req,
  output cpsrw_pkg::div_rsp_t   rsp
);
  localparam int unsigned NW = cpsrw_pkg::DIV_NW;
  localparam int unsigned DW = cpsrw_pkg::DIV_DW;

  logic [NW-1:0] num_r, q_r;
  logic [DW-1:0] den_r, rem_r;
  logic [5:0]    cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   trial;
  logic          ge;

  // one trial subtraction
  assign trial = {rem_r, num_r[NW-1]};
  assign ge    = (trial >= {1'b0, den_r});

  // datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NW-2:0], 1'b0};
      rem_r <= ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      q_r   <= {q_r[NW-2:0], ge};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= req.iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = q_r;
endmodule

[src/cpsrw_back.sv]
// cpsrw_back: sequencer that takes the clock divider, works out delay word, steps, offset
// and deviation, then emits the eight words. Depends on cpsrw_pkg; drives cpsrw_div.
module cpsrw_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cpsrw_pkg::item_t     item,
  input  logic                 item_valid,
  output logic                 item_pop,
  output cpsrw_pkg::div_req_t  div_req,
  input  cpsrw_pkg::div_rsp_t  div_rsp,
  output logic                 ow_push,
  output cpsrw_pkg::oword_t    ow,
  input  logic                 ow_full
);
  cpsrw_pkg::back_state_t state_r, state_nxt;

  logic [8:0]  clk1_r;
  logic [11:0] dword_r;
  logic [19:0] steps_r;
  logic [3:0]  k_r;
  logic [37:0] den_r;
  logic [15:0] dev_r;
  logic [2:0]  idx_r;

  logic [19:0] steps_c;
  logic [15:0] dev_c;
  logic        k_adv;
  logic        emit_go;

  // clamps on the divider result
  always_comb begin
    if (div_rsp.quot == '0) begin
      steps_c = 20'd1;
    end else if (div_rsp.quot > 41'(cpsrw_pkg::STEPS_MAX)) begin
      steps_c = cpsrw_pkg::STEPS_MAX;
    end else begin
      steps_c = div_rsp.quot[19:0];
    end
    if (div_rsp.quot == '0) begin
      dev_c = 16'd1;
    end else if (div_rsp.quot > 41'(cpsrw_pkg::DEV_MAX)) begin
      dev_c = cpsrw_pkg::DEV_MAX;
    end else begin
      dev_c = div_rsp.quot[15:0];
    end
  end

  // offset search: grow k, up to 15, while bw*256 exceeds 5*steps*2^k
  assign k_adv   = (k_r != cpsrw_pkg::OFFS_MAX) && (38'({item.bw, 8'b0}) > den_r);
  assign emit_go = !ow_full;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cpsrw_pkg::BS_IDLE:  if (item_valid) state_nxt = cpsrw_pkg::BS_CLK1;
      cpsrw_pkg::BS_CLK1:  state_nxt = cpsrw_pkg::BS_DWORD;
      cpsrw_pkg::BS_DWORD: if (div_rsp.done) state_nxt = cpsrw_pkg::BS_STEPS;
      cpsrw_pkg::BS_STEPS: if (div_rsp.done) state_nxt = cpsrw_pkg::BS_OFFS;
      cpsrw_pkg::BS_OFFS:  if (!k_adv) state_nxt = cpsrw_pkg::BS_DEV;
      cpsrw_pkg::BS_DEV:   if (div_rsp.done) state_nxt = cpsrw_pkg::BS_EMIT;
      cpsrw_pkg::BS_EMIT: begin
        if (emit_go && idx_r == cpsrw_pkg::IDX_R0) state_nxt = cpsrw_pkg::BS_IDLE;
      end
      default: state_nxt = cpsrw_pkg::BS_IDLE;
    endcase
  end

  // outputs: divider requests, word pushes, request pop
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    div_req.iters = '0;
    ow_push       = 1'b0;
    item_pop      = 1'b0;
    case (state_r)
      cpsrw_pkg::BS_DWORD: begin
        div_req.start = !div_rsp.busy && !div_rsp.done;
        div_req.num   = {item.count, 20'b0};
        div_req.den   = 40'(clk1_r);
        div_req.iters = cpsrw_pkg::ITER_DWORD;
      end
      cpsrw_pkg::BS_STEPS: begin
        div_req.start = !div_rsp.busy && !div_rsp.done;
        div_req.num   = {item.rt40 + 22'(clk1_r), 19'b0};
        div_req.den   = 40'({clk1_r, 1'b0});
        div_req.iters = cpsrw_pkg::ITER_STEPS;
      end
      cpsrw_pkg::BS_DEV: begin
        div_req.start = !div_rsp.busy && !div_rsp.done;
        div_req.num   = 41'({item.bw, 24'b0}) + 41'(den_r);
        div_req.den   = 40'({den_r, 1'b0});
        div_req.iters = cpsrw_pkg::ITER_DEV;
      end
      cpsrw_pkg::BS_EMIT: begin
        ow_push  = emit_go;
        item_pop = emit_go && (idx_r == cpsrw_pkg::IDX_R0);
      end
      default: ;
    endcase
  end

  // word assembly, R7 first
  always_comb begin
    ow.last = (idx_r == cpsrw_pkg::IDX_R0);
    case (idx_r)
      cpsrw_pkg::IDX_R7: ow.word = cpsrw_pkg::R7_FIXED | {17'b0, dword_r, 3'b0};
      cpsrw_pkg::IDX_R6: ow.word = cpsrw_pkg::R6_FIXED | {9'b0, steps_r, 3'b0};
      cpsrw_pkg::IDX_R5: ow.word = cpsrw_pkg::R5_FIXED | {9'b0, k_r, dev_r, 3'b0};
      cpsrw_pkg::IDX_R4: ow.word = cpsrw_pkg::R4_WORD;
      cpsrw_pkg::IDX_R3: ow.word = cpsrw_pkg::R3_FIXED | {21'b0, item.ramp_tri, 10'b0};
      cpsrw_pkg::IDX_R2: ow.word = cpsrw_pkg::R2_FIXED | {20'b0, clk1_r, 3'b0};
      cpsrw_pkg::IDX_R1: ow.word = cpsrw_pkg::R1_WORD;
      cpsrw_pkg::IDX_R0: begin
        ow.word = cpsrw_pkg::R0_FIXED | {5'b0, item.integ, item.fmsb, 14'b0};
      end
      default: ow.word = '0;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpsrw_pkg::BS_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == cpsrw_pkg::BS_EMIT && emit_go) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // captured results
  always_ff @(posedge clk) begin
    case (state_r)
      cpsrw_pkg::BS_CLK1:  clk1_r <= item.clk1;
      cpsrw_pkg::BS_DWORD: if (div_rsp.done) dword_r <= div_rsp.quot[11:0];
      cpsrw_pkg::BS_STEPS: begin
        if (div_rsp.done) begin
          steps_r <= steps_c;
          den_r   <= 38'(23'(steps_c) * 23'd5);
          k_r     <= '0;
        end
      end
      cpsrw_pkg::BS_OFFS: begin
        if (k_adv) begin
          k_r   <= k_r + 1'b1;
          den_r <= {den_r[36:0], 1'b0};
        end
      end
      cpsrw_pkg::BS_DEV:   if (div_rsp.done) dev_r <= dev_c;
      default: ;
    endcase
  end
endmodule

[src/chirp_pll_sweep_register_words_core.sv]
// Channel   | Ports                                                   | Handshake
// request   | in_ramp_time_us, in_ramp_delay_us, in_start_freq_10mhz, | push / full
//           | in_bandwidth_mhz, in_triangular                         |
// word      | out_register_word, out_last_word                        | pop / empty
//
// One request gives eight words, R7 first, R0 flagged last. The sequencer works one request
// at a time: two bit-serial divisions (21 and 22 bits) in the shared divider, an offset
// search with k up to 15 and a third division (41 bits), then the words are emitted.
// Requests queue in front while a previous one is worked; words queue behind, and a full
// word queue stalls the sequencer.
// Reset (rst_n low, synchronous) empties both queues and returns the sequencer to idle.
// Depends on cpsrw_pkg, cpsrw_front, cpsrw_div, cpsrw_back, cpsrw_fifo.
module chirp_pll_sweep_register_words_core #(
  parameter int unsigned IN_DEPTH  = cpsrw_pkg::IN_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = cpsrw_pkg::OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_ramp_time_us,
  input  logic [15:0] in_ramp_delay_us,
  input  logic [15:0] in_start_freq_10mhz,
  input  logic [15:0] in_bandwidth_mhz,
  input  logic        in_triangular,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_register_word,
  output logic        out_last_word
);
  cpsrw_pkg::item_t    item;
  logic                item_valid, item_pop;
  cpsrw_pkg::div_req_t div_req;
  cpsrw_pkg::div_rsp_t div_rsp;
  cpsrw_pkg::oword_t   ow, ow_head;
  logic                ow_push, ow_full;
  logic [$bits(cpsrw_pkg::oword_t)-1:0] ow_rdata;

  cpsrw_front #(.DEPTH(IN_DEPTH)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .ramp_time_us     (in_ramp_time_us),
    .ramp_delay_us    (in_ramp_delay_us),
    .start_freq_10mhz (in_start_freq_10mhz),
    .bandwidth_mhz    (in_bandwidth_mhz),
    .triangular       (in_triangular),
    .item             (item),
    .item_valid       (item_valid),
    .item_pop         (item_pop)
  );

  cpsrw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  cpsrw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .ow_push    (ow_push),
    .ow         (ow),
    .ow_full    (ow_full)
  );

  // word queue towards the consumer
  cpsrw_fifo #(.W($bits(cpsrw_pkg::oword_t)), .DEPTH(OUT_DEPTH)) u_oq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ow_push),
    .wdata (ow),
    .full  (ow_full),
    .pop   (pop),
    .rdata (ow_rdata),
    .empty (empty)
  );

  assign ow_head           = cpsrw_pkg::oword_t'(ow_rdata);
  assign out_register_word = ow_head.word;
  assign out_last_word     = ow_head.last;
endmodule

[src/cpsrw_checker.sv]
// cpsrw_checker: port-level checks on the word stream of the top level.
// Depends on nothing but the top level's ports; bound below.
module cpsrw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] out_register_word,
  input logic        out_last_word
);
  // queues come out of reset empty with room
  a_reset: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("queues not cleared by reset");

  // the flagged word is always register 0
  a_last_r0: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last_word) |-> (out_register_word[2:0] == 3'd0))
    else $error("last word is not register 0");

  // words run downwards in address
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !out_last_word) ##1 !empty |->
      (out_register_word[2:0] == 3'($past(out_register_word[2:0]) - 3'd1)))
    else $error("word address out of sequence");

  // a waiting word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_register_word) && $stable(out_last_word)))
    else $error("waiting word changed");
endmodule

bind chirp_pll_sweep_register_words_core cpsrw_checker u_cpsrw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .full              (full),
  .empty             (empty),
  .pop               (pop),
  .out_register_word (out_register_word),
  .out_last_word     (out_last_word)
);
